[hw/rtl/ipv4cs_pkg.sv]
// Shared types, constants and the one's complement adder for the IPv4/UDP
// checksum generator. No dependencies.
package ipv4cs_pkg;

    // Frame positions and spans are compared at 17 bits so that
    // 14 + total_length never wraps.
    typedef logic [16:0] t_span;

    localparam t_span ETH_HDR        = 17'd14;
    localparam t_span IP_HDR_END     = 17'd34;
    localparam t_span POS_ETHERTYPE  = 17'd13;
    localparam t_span POS_IHL        = 17'd14;
    localparam t_span POS_TOTAL_LEN  = 17'd17;
    localparam t_span POS_PROTOCOL   = 17'd23;
    localparam t_span POS_IP_FIRST   = 17'd15;
    localparam t_span POS_IP_CSUM    = 17'd25;
    localparam t_span POS_IP_LAST    = 17'd33;
    localparam t_span POS_ADDR_FIRST = 17'd27;
    localparam t_span UDP_CSUM_OFS   = 17'd6;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'h11;
    localparam logic [3:0]  MIN_IHL        = 4'd5;

    // Per-frame totals handed from the accumulator to the finishing stage.
    typedef struct packed {
        logic [15:0] ip_sum;
        logic [15:0] udp_sum;
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic        type_ok;
        logic        proto_ok;
    } t_frame_sums;

    // One's complement 16-bit add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + 16'(s[16]);
    endfunction

endpackage

[hw/rtl/ipv4cs_accum.sv]
// Running-sum stage: tracks the byte position, header fields and both
// one's complement sums, and captures the totals at the last byte of a frame.
// Depends on ipv4cs_pkg.
module ipv4cs_accum #(
    parameter int POSITION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_enable,
    input  logic                     i_valid,
    input  logic [7:0]               i_byte,
    input  logic                     i_last,
    output logic                     o_valid,
    output ipv4cs_pkg::t_frame_sums  o_sums,
    output logic [POSITION_BITS-1:0] o_covered
);
    import ipv4cs_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [15:0]              r_ip_sum, n_ip_sum;
    logic [15:0]              r_udp_sum, n_udp_sum;
    logic [7:0]               r_held, n_held;
    logic [3:0]               r_hwords, n_hwords;
    logic [15:0]              r_tlen, n_tlen;
    logic                     r_type_ok, n_type_ok;
    logic                     r_proto_ok, n_proto_ok;
    logic                     r_snap_valid;
    t_frame_sums              r_snap;
    logic [POSITION_BITS-1:0] r_covered;

    logic        take;
    logic        odd;
    logic [15:0] word;
    t_span       p;
    t_span       pay_start;
    t_span       pay_end;
    logic        ip_add;
    logic        addr_add;
    logic        in_payload;
    logic        udp_add;
    logic [15:0] udp_operand;

    always_comb begin
        take      = i_valid && (r_pos != POS_MAX);
        odd       = r_pos[0];
        word      = {r_held, i_byte};
        p         = 17'(r_pos);
        pay_start = ETH_HDR + {11'd0, r_hwords, 2'b00};
        pay_end   = ETH_HDR + {1'b0, r_tlen};

        ip_add   = odd && p >= POS_IP_FIRST && p <= POS_IP_LAST && p != POS_IP_CSUM;
        addr_add = odd && p >= POS_ADDR_FIRST && p <= POS_IP_LAST;
        in_payload = p >= pay_start && p < pay_end &&
                     p != 17'(pay_start + UDP_CSUM_OFS) &&
                     p != 17'(pay_start + UDP_CSUM_OFS + 17'd1);

        // The address words and the payload overlap only when the header
        // length is below the minimum, and then no checksum is reported.
        udp_add     = 1'b0;
        udp_operand = word;
        if (addr_add) begin
            udp_add = 1'b1;
        end else if (in_payload && odd) begin
            udp_add = 1'b1;
        end else if (in_payload && (17'(p + 17'd1) == pay_end)) begin
            udp_add     = 1'b1;
            udp_operand = {i_byte, 8'h00};
        end

        n_pos      = r_pos;
        n_ip_sum   = r_ip_sum;
        n_udp_sum  = r_udp_sum;
        n_held     = r_held;
        n_hwords   = r_hwords;
        n_tlen     = r_tlen;
        n_type_ok  = r_type_ok;
        n_proto_ok = r_proto_ok;
        if (take) begin
            n_pos = r_pos + 1'b1;
            if (p == POS_ETHERTYPE) n_type_ok  = (word == ETHERTYPE_IPV4);
            if (p == POS_IHL)       n_hwords   = i_byte[3:0];
            if (p == POS_TOTAL_LEN) n_tlen     = word;
            if (p == POS_PROTOCOL)  n_proto_ok = (i_byte == PROTO_UDP);
            if (ip_add)             n_ip_sum   = oc_add(r_ip_sum, word);
            if (udp_add)            n_udp_sum  = oc_add(r_udp_sum, udp_operand);
            if (!odd)               n_held     = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_ip_sum     <= '0;
            r_udp_sum    <= '0;
            r_held       <= '0;
            r_hwords     <= '0;
            r_tlen       <= '0;
            r_type_ok    <= 1'b0;
            r_proto_ok   <= 1'b0;
            r_snap_valid <= 1'b0;
        end else if (i_enable) begin
            r_snap_valid <= i_valid && i_last;
            if (i_valid && i_last) begin
                // Frame done: per-frame state starts over for the next one.
                r_pos      <= '0;
                r_ip_sum   <= '0;
                r_udp_sum  <= '0;
                r_held     <= '0;
                r_hwords   <= '0;
                r_tlen     <= '0;
                r_type_ok  <= 1'b0;
                r_proto_ok <= 1'b0;
            end else begin
                r_pos      <= n_pos;
                r_ip_sum   <= n_ip_sum;
                r_udp_sum  <= n_udp_sum;
                r_held     <= n_held;
                r_hwords   <= n_hwords;
                r_tlen     <= n_tlen;
                r_type_ok  <= n_type_ok;
                r_proto_ok <= n_proto_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enable && i_valid && i_last) begin
            r_snap.ip_sum       <= n_ip_sum;
            r_snap.udp_sum      <= n_udp_sum;
            r_snap.header_words <= n_hwords;
            r_snap.total_length <= n_tlen;
            r_snap.type_ok      <= n_type_ok;
            r_snap.proto_ok     <= n_proto_ok;
            r_covered           <= n_pos;
        end
    end

    assign o_valid   = r_snap_valid;
    assign o_sums    = r_snap;
    assign o_covered = r_covered;

endmodule

[hw/rtl/ipv4cs_final.sv]
// Finishing stage: folds the protocol and payload length into the UDP sum,
// inverts both sums and works out the applies and short-frame flags.
// Depends on ipv4cs_pkg.
module ipv4cs_final #(
    parameter int POSITION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_enable,
    input  logic                     i_valid,
    input  ipv4cs_pkg::t_frame_sums  i_sums,
    input  logic [POSITION_BITS-1:0] i_covered,
    output logic                     o_valid,
    output logic [15:0]              o_ip_checksum,
    output logic [15:0]              o_udp_checksum,
    output logic                     o_applies,
    output logic                     o_short_frame
);
    import ipv4cs_pkg::*;

    logic        r_valid;
    logic [15:0] r_ip_csum, n_ip_csum;
    logic [15:0] r_udp_csum, n_udp_csum;
    logic        r_applies, n_applies;
    logic        r_short, n_short;

    logic [15:0] hlen;
    logic [15:0] plen;
    logic [15:0] usum;
    t_span       cov;

    always_comb begin
        hlen      = {10'd0, i_sums.header_words, 2'b00};
        n_applies = i_sums.type_ok && i_sums.proto_ok &&
                    i_sums.header_words >= MIN_IHL && i_sums.total_length >= hlen;
        plen      = i_sums.total_length - hlen;
        usum      = oc_add(oc_add(i_sums.udp_sum, {8'h00, PROTO_UDP}), plen);
        n_ip_csum  = ~i_sums.ip_sum;
        // A UDP checksum of zero means "none", so zero is sent as all ones.
        n_udp_csum = (usum == 16'hffff) ? 16'hffff : ~usum;
        if (!n_applies) begin
            n_ip_csum  = '0;
            n_udp_csum = '0;
        end
        cov     = 17'(i_covered);
        n_short = i_sums.type_ok &&
                  (cov < IP_HDR_END || cov < ETH_HDR + {1'b0, i_sums.total_length});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_enable) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enable && i_valid) begin
            r_ip_csum  <= n_ip_csum;
            r_udp_csum <= n_udp_csum;
            r_applies  <= n_applies;
            r_short    <= n_short;
        end
    end

    assign o_valid        = r_valid;
    assign o_ip_checksum  = r_ip_csum;
    assign o_udp_checksum = r_udp_csum;
    assign o_applies      = r_applies;
    assign o_short_frame  = r_short;

endmodule

[hw/rtl/ipv4_udp_checksum_generator.sv]
// IPv4/UDP checksum generator. Takes an Ethernet frame one byte per cycle
// and, once the last byte accepted has passed through the pipeline, offers one
// item with the IPv4 header checksum, the UDP checksum and two flags. A new byte
// is taken in every cycle; the pipeline is an input register, the running-sum
// accumulator and a finishing stage, and it stalls as a whole only while a
// result waits at the output. Checksums read zero when the frame is not IPv4
// UDP with sane lengths. Frames longer than 2^POSITION_BITS - 1 bytes are summed
// up to that point only. Depends on ipv4cs_pkg, ipv4cs_accum and ipv4cs_final.
module ipv4_udp_checksum_generator #(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // frame_byte[7:0]
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // ip_checksum[15:0], udp_checksum[31:16]
    output logic [7:0]  o_m_axis_tuser    // applies[0], short_frame[1], zero[7:2]
);
    import ipv4cs_pkg::*;

    logic                     advance;
    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    logic                     r_in_last;
    logic                     snap_valid;
    t_frame_sums              snap_sums;
    logic [POSITION_BITS-1:0] snap_covered;
    logic                     out_valid;
    logic [15:0]              ip_csum;
    logic [15:0]              udp_csum;
    logic                     applies;
    logic                     short_frame;

    // Every stage moves together unless a finished item is being held.
    assign advance         = !out_valid || i_m_axis_tready;
    assign o_s_axis_tready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    ipv4cs_accum #(
        .POSITION_BITS(POSITION_BITS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_enable  (advance),
        .i_valid   (r_in_valid),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .o_valid   (snap_valid),
        .o_sums    (snap_sums),
        .o_covered (snap_covered)
    );

    ipv4cs_final #(
        .POSITION_BITS(POSITION_BITS)
    ) u_final (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enable       (advance),
        .i_valid        (snap_valid),
        .i_sums         (snap_sums),
        .i_covered      (snap_covered),
        .o_valid        (out_valid),
        .o_ip_checksum  (ip_csum),
        .o_udp_checksum (udp_csum),
        .o_applies      (applies),
        .o_short_frame  (short_frame)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = {udp_csum, ip_csum};
    assign o_m_axis_tuser  = {6'd0, short_frame, applies};

    a_last_makes_snapshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && r_in_last) |=> snap_valid)
        else $error("last byte did not produce frame totals");

    a_no_spurious_snapshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !(r_in_valid && r_in_last)) |=> !snap_valid)
        else $error("frame totals without a last byte");

    a_snapshot_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && snap_valid) |=> out_valid)
        else $error("frame totals lost before the output register");

    a_zero_when_not_applicable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !applies) |-> (ip_csum == 16'h0000 && udp_csum == 16'h0000))
        else $error("checksums given for a frame that is not IPv4 UDP");

    a_udp_never_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && applies) |-> (udp_csum != 16'h0000))
        else $error("UDP checksum of zero sent for an applicable frame");

endmodule
